// ----- src/sos_pkg.sv -----
// Shared types, codes and defaults for the set-of-stacks block.
package sos_pkg;

    // Default sizes of the stack set.
    localparam int NUM_STACKS_DEF  = 128;
    localparam int STACK_DEPTH_DEF = 8;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed field widths of the request and the result.
    localparam int FUNC_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int STACK_NUM_W = 7;
    localparam int CAP_W       = 4;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 4'd5;

    // Operation codes; the fourth code is a no-op.
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_AT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADNUM = 2'd3
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [VALUE_W-1:0] push_value;
        logic [STACK_NUM_W-1:0]   target_stack;
    } t_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pop_value;
        t_status                  status;
        logic [STACK_NUM_W-1:0]   stack_used;
    } t_rsp;

endpackage

// ----- src/sos_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sos_apb_regs.sv -----
// APB configuration register holding the per-stack capacity.
module sos_apb_regs import sos_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [CAP_W-1:0]  o_capacity
);

    logic [CAP_W-1:0] r_cap;
    logic             hit;

    assign hit = (paddr[APB_AW-1:2] == REG_CAPACITY);

    // Register write on the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // Read data; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (psel && !pwrite && hit) begin
            prdata = APB_DW'(r_cap);
        end
    end

    assign pready     = 1'b1;
    assign o_capacity = r_cap;

endmodule

// ----- src/sos_engine.sv -----
// Stack engine: request register, fill-count and item memories, result register.
module sos_engine import sos_pkg::*; #(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_req             i_req,
    input  logic [CAP_W-1:0] i_capacity,
    output logic             o_valid,
    output t_rsp             o_rsp
);

    localparam int SW     = (NUM_STACKS > 2) ? $clog2(NUM_STACKS) : 1;
    localparam int IW     = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW     = $clog2(STACK_DEPTH + 1);
    localparam int MW     = (FW > CAP_W) ? FW : CAP_W;
    localparam int XW     = ((SW > STACK_NUM_W) ? SW : STACK_NUM_W) + 1;
    localparam int SDEPTH = NUM_STACKS * (2 ** IW);
    localparam int LAST   = NUM_STACKS - 1;

    // Stage registers and the current-stack state.
    logic                   r_s1_v;
    t_req                   r_s1_req;
    logic [SW-1:0]          r_cur;
    logic [FW-1:0]          r_cur_fill;
    logic                   r_fwd;
    logic [FW-1:0]          r_fwd_data;
    logic                   r_s2_v;
    t_status                r_s2_status;
    logic [STACK_NUM_W-1:0] r_s2_used;
    logic                   r_s2_take;

    logic [SW-1:0]          n_cur;
    logic [FW-1:0]          n_cur_fill;

    // Memory ports.
    logic                   fill_we;
    logic [SW-1:0]          fill_waddr;
    logic [FW-1:0]          fill_wdata;
    logic [SW-1:0]          fill_raddr;
    logic [FW-1:0]          fill_q;
    logic                   st_we;
    logic [SW+IW-1:0]       st_waddr;
    logic [DATA_WIDTH-1:0]  st_wdata;
    logic [SW+IW-1:0]       st_raddr;
    logic [DATA_WIDTH-1:0]  st_q;

    // Stage-one working signals.
    logic [FW-1:0]          ecap;
    logic [FW-1:0]          mem_fill;
    logic [FW-1:0]          mem_fill_m1;
    logic [FW-1:0]          cur_fill_m1;
    logic [SW-1:0]          cur_inc;
    logic [SW-1:0]          cur_dec;
    logic [SW-1:0]          tgt;
    logic                   tgt_bad;
    logic [63:0]            push_ext;
    logic [63:0]            pop_ext;
    t_status                status;
    logic [STACK_NUM_W-1:0] used;
    logic                   take;

    // Capacity as used: zero acts as one, large values clip to the depth.
    always_comb begin
        if (i_capacity == '0) begin
            ecap = FW'(1);
        end else if (MW'(i_capacity) > MW'(STACK_DEPTH)) begin
            ecap = FW'(STACK_DEPTH);
        end else begin
            ecap = FW'(i_capacity);
        end
    end

    // The fill memory holds every stack but the current one; the current
    // count lives in r_cur_fill. A write at the read edge is forwarded.
    assign mem_fill    = r_fwd ? r_fwd_data : fill_q;
    assign mem_fill_m1 = mem_fill - FW'(1);
    assign cur_fill_m1 = r_cur_fill - FW'(1);
    assign cur_inc     = r_cur + SW'(1);
    assign cur_dec     = r_cur - SW'(1);
    assign tgt         = SW'(r_s1_req.target_stack);
    assign tgt_bad     = (XW'(r_s1_req.target_stack) >= XW'(NUM_STACKS)) ||
                         (XW'(r_s1_req.target_stack) > XW'(r_cur));
    assign push_ext    = 64'(r_s1_req.push_value);
    assign st_wdata    = push_ext[DATA_WIDTH-1:0];

    // Stage one: decide the operation and update the stack state.
    always_comb begin
        n_cur      = r_cur;
        n_cur_fill = r_cur_fill;
        fill_we    = 1'b0;
        fill_waddr = r_cur;
        fill_wdata = r_cur_fill;
        st_we      = 1'b0;
        st_waddr   = {r_cur, IW'(r_cur_fill)};
        st_raddr   = {r_cur, IW'(cur_fill_m1)};
        status     = ST_OK;
        used       = STACK_NUM_W'(r_cur);
        take       = 1'b0;
        if (r_s1_v) begin
            unique case (r_s1_req.func)
                FUNC_PUSH: begin
                    if (r_cur_fill >= ecap) begin
                        if (r_cur == SW'(LAST)) begin
                            status = ST_FULL;
                        end else begin
                            // Open the next stack and retire this count.
                            n_cur      = cur_inc;
                            n_cur_fill = FW'(1);
                            fill_we    = 1'b1;
                            st_we      = 1'b1;
                            st_waddr   = {cur_inc, IW'(0)};
                            used       = STACK_NUM_W'(cur_inc);
                        end
                    end else begin
                        n_cur_fill = r_cur_fill + FW'(1);
                        st_we      = 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (r_cur_fill == '0 && r_cur != '0) begin
                        // Step back one stack and pop there.
                        n_cur = cur_dec;
                        used  = STACK_NUM_W'(cur_dec);
                        if (mem_fill == '0) begin
                            status     = ST_EMPTY;
                            n_cur_fill = '0;
                        end else begin
                            n_cur_fill = mem_fill_m1;
                            take       = 1'b1;
                            st_raddr   = {cur_dec, IW'(mem_fill_m1)};
                        end
                    end else if (r_cur_fill == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        n_cur_fill = cur_fill_m1;
                        take       = 1'b1;
                    end
                end
                FUNC_POP_AT: begin
                    used = r_s1_req.target_stack;
                    if (tgt_bad) begin
                        status = ST_BADNUM;
                    end else if (tgt == r_cur) begin
                        if (r_cur_fill == '0) begin
                            status = ST_EMPTY;
                        end else begin
                            n_cur_fill = cur_fill_m1;
                            take       = 1'b1;
                        end
                    end else if (mem_fill == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        fill_we    = 1'b1;
                        fill_waddr = tgt;
                        fill_wdata = mem_fill_m1;
                        take       = 1'b1;
                        st_raddr   = {tgt, IW'(mem_fill_m1)};
                    end
                end
                default: begin
                    // Unused code: no change, plain ok result.
                end
            endcase
        end
    end

    // Fill read for the request being accepted, against the updated stack.
    assign fill_raddr = (i_req.func == FUNC_POP_AT) ? SW'(i_req.target_stack)
                                                    : n_cur - SW'(1);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_cur      <= '0;
            r_cur_fill <= '0;
            r_fwd      <= 1'b0;
            r_s2_v     <= 1'b0;
        end else begin
            r_s1_v     <= i_start;
            r_cur      <= n_cur;
            r_cur_fill <= n_cur_fill;
            r_fwd      <= fill_we && (fill_waddr == fill_raddr);
            r_s2_v     <= r_s1_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_s1_req    <= i_req;
        r_fwd_data  <= fill_wdata;
        r_s2_status <= status;
        r_s2_used   <= used;
        r_s2_take   <= take;
    end

    sos_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_STACKS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (fill_raddr),
        .o_rdata (fill_q)
    );

    sos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SDEPTH)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    // Stage two: the popped item arrives from the item memory.
    assign pop_ext          = 64'(st_q);
    assign o_valid          = r_s2_v;
    assign o_rsp.pop_value  = r_s2_take ? pop_ext[VALUE_W-1:0] : '0;
    assign o_rsp.status     = r_s2_status;
    assign o_rsp.stack_used = r_s2_used;

`ifndef NO_ASSERTIONS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_fill <= FW'(STACK_DEPTH))
        else $error("current fill count above stack depth");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= SW'(LAST))
        else $error("current stack outside the stack set");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |=> r_s2_v)
        else $error("request lost between stages");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_req.func == FUNC_PUSH && status == ST_OK) |=> r_cur_fill != '0)
        else $error("successful push left the current stack empty");
`endif

endmodule

// ----- src/set_of_stacks_core.sv -----
// Top level of the set-of-stacks block: configuration register and stack engine.
//
// A chain of fixed-capacity stacks that acts as one stack, with push, pop and
// pop from a named stack. One request is taken in every clock cycle; busy is
// always low. Each request gives exactly one result, shown on o_rsp with
// o_valid high for one cycle, after the request and result registers.
// The fill-count memory is read at the accepting edge, from an address formed
// in the cycle before it. The item memory is read at the next edge, which also
// loads the result register. Results come in request order and cannot be held
// off. No clearing pass is needed after reset.
module set_of_stacks_core import sos_pkg::*; #(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_valid,
    output t_rsp              o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CAP_W-1:0] capacity;

    // The engine takes one request per cycle.
    assign busy = 1'b0;

    sos_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    sos_engine #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start && !busy),
        .i_req      (i_req),
        .i_capacity (capacity),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

endmodule
